// ===== sv/rpc_pkg.sv =====
// Shared types, table layout constants and saturating Q32.32 helpers for the
// quadratic point transform. No dependencies.
package rpc_pkg;

    localparam int TERMS_PER_AXIS = 19;
    localparam int TABLE_WORDS    = 48;
    localparam int ADDR_W         = 6;

    localparam logic [ADDR_W-1:0] OFF_BASE     = ADDR_W'(2 * TERMS_PER_AXIS);
    localparam logic [ADDR_W-1:0] DST_OFF_BASE = ADDR_W'(2 * TERMS_PER_AXIS + 3);
    localparam logic [ADDR_W-1:0] SCL_BASE     = ADDR_W'(2 * TERMS_PER_AXIS + 5);
    localparam logic [ADDR_W-1:0] DST_SCL_BASE = ADDR_W'(2 * TERMS_PER_AXIS + 8);

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_XFORM = 2'd1;
    localparam logic [1:0] MODE_RESID = 2'd2;

    localparam logic [63:0] ONE_Q   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

    // One queued item, already classified by the front end.
    typedef struct packed {
        logic              is_load;
        logic              resid;
        logic [ADDR_W-1:0] index;
        logic [63:0]       value;
        logic [63:0]       sx;
        logic [63:0]       sy;
        logic [63:0]       sz;
        logic [63:0]       ox;
        logic [63:0]       oy;
        logic              last;
    } q_entry_t;

    typedef struct packed {
        logic [63:0] v;
        logic        err;
    } sres_t;

    function automatic sres_t sat_mag(input logic neg, input logic hi_nz,
                                      input logic [63:0] lo);
        sres_t r;
        if (!hi_nz && !lo[63]) begin
            r.v   = neg ? (64'd0 - lo) : lo;
            r.err = 1'b0;
        end else if (neg && !hi_nz && lo == SAT_MIN) begin
            r.v   = SAT_MIN;
            r.err = 1'b0;
        end else begin
            r.v   = neg ? SAT_MIN : SAT_MAX;
            r.err = 1'b1;
        end
        return r;
    endfunction

    function automatic sres_t sadd(input logic [63:0] a, input logic [63:0] b);
        sres_t       r;
        logic [63:0] s;
        s = a + b;
        r.err = (a[63] == b[63]) && (s[63] != a[63]);
        r.v   = r.err ? (a[63] ? SAT_MIN : SAT_MAX) : s;
        return r;
    endfunction

    function automatic sres_t ssub(input logic [63:0] a, input logic [63:0] b);
        sres_t       r;
        logic [63:0] s;
        s = a - b;
        r.err = (a[63] != b[63]) && (s[63] != a[63]);
        r.v   = r.err ? (a[63] ? SAT_MIN : SAT_MAX) : s;
        return r;
    endfunction

endpackage

// ===== sv/rpc_quadratic_point_transform.sv =====
// Top level of the second-order rational polynomial point transform.
// Depends on rpc_pkg, rpc_front and rpc_back.
//
// Items enter on the in_valid/in_ready channel. A load item (mode 0) writes one
// word of the 48-word model table and gives no result; mode 3 items and loads
// beyond the table are dropped. A point item (mode 1 transform, mode 2 residual)
// gives one result on the out_valid/out_ready channel, in order.
// The front end queues up to two items and takes a new one in any cycle the
// queue has room, also while a result waits to be taken.
// A load is carried out as the queue pops it. A point runs in the back end:
// five divisions (96 quotient bits at one per cycle) in the shared divider,
// 46 multiplications in the shared multiplier, and the table reads, queue pop
// and final additions, all run by one sequencer that reads one word per cycle.
// When the receiver stalls, the finished result is held in the output register;
// the back end waits on the next point's last step and the queue fills, after
// which in_ready falls.
// Reset empties the queue and the output register; the table is not cleared and
// must be loaded before points are sent.
module rpc_quadratic_point_transform (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [5:0]         table_index,
    input  logic signed [63:0] table_value,
    input  logic signed [63:0] src_x,
    input  logic signed [63:0] src_y,
    input  logic signed [63:0] src_z,
    input  logic signed [63:0] obs_x,
    input  logic signed [63:0] obs_y,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] out_x,
    output logic signed [63:0] out_y,
    output logic               range_error,
    output logic               last_out
);

    logic              q_valid, q_pop;
    rpc_pkg::q_entry_t q_head;

    rpc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .table_index (table_index),
        .table_value (table_value),
        .src_x       (src_x),
        .src_y       (src_y),
        .src_z       (src_z),
        .obs_x       (obs_x),
        .obs_y       (obs_y),
        .last_in     (last_in),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop)
    );

    rpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .range_error (range_error),
        .last_out    (last_out)
    );

endmodule

// ===== sv/rpc_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on rpc_pkg.
module rpc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              mode,
    input  logic [5:0]              table_index,
    input  logic signed [63:0]      table_value,
    input  logic signed [63:0]      src_x,
    input  logic signed [63:0]      src_y,
    input  logic signed [63:0]      src_z,
    input  logic signed [63:0]      obs_x,
    input  logic signed [63:0]      obs_y,
    input  logic                    last_in,
    output logic                    q_valid,
    output rpc_pkg::q_entry_t       q_head,
    input  logic                    q_pop
);

    rpc_pkg::q_entry_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       keep, push;
    rpc_pkg::q_entry_t entry;

    // Unused modes and loads beyond the table are dropped here.
    always_comb
    begin
        case (mode)
            rpc_pkg::MODE_LOAD:  keep = (table_index < 6'(rpc_pkg::TABLE_WORDS));
            rpc_pkg::MODE_XFORM: keep = 1'b1;
            rpc_pkg::MODE_RESID: keep = 1'b1;
            default:             keep = 1'b0;
        endcase
        entry.is_load = (mode == rpc_pkg::MODE_LOAD);
        entry.resid   = (mode == rpc_pkg::MODE_RESID);
        entry.index   = table_index;
        entry.value   = table_value;
        entry.sx      = src_x;
        entry.sy      = src_y;
        entry.sz      = src_z;
        entry.ox      = obs_x;
        entry.oy      = obs_y;
        entry.last    = last_in;
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== sv/rpc_mul.sv =====
// Q32.32 saturating multiplier built from four 32x32 partial products.
// Depends on rpc_pkg.
module rpc_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output rpc_pkg::sres_t res
);

    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  x_reg, y_reg, pp_reg;
    logic [1:0]   sh_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [31:0]  xh, yh;
    logic [127:0] pp_wide;

    assign xh = cnt_reg[1] ? x_reg[63:32] : x_reg[31:0];
    assign yh = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_wide = {64'd0, pp_reg};
            2'd1:    pp_wide = {32'd0, pp_reg, 32'd0};
            default: pp_wide = {pp_reg, 64'd0};
        endcase
    end

    // Partial products are taken on counts 0..3 and each is summed in the cycle after.
    assign done = busy_reg && (cnt_reg == 3'd5);
    assign res  = rpc_pkg::sat_mag(neg_reg, acc_reg[127:96] != 32'd0, acc_reg[95:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'd5)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= a[63] ? (64'd0 - a) : a;
            y_reg   <= b[63] ? (64'd0 - b) : b;
            neg_reg <= a[63] ^ b[63];
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
            begin
                pp_reg <= {32'd0, xh} * {32'd0, yh};
                sh_reg <= 2'({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]});
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                acc_reg <= acc_reg + pp_wide;
            end
        end
    end

endmodule

// ===== sv/rpc_div.sv =====
// Q32.32 saturating divider, restoring, one quotient bit per cycle.
// Depends on rpc_pkg.
module rpc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] n,
    input  logic [63:0] d,
    output logic        done,
    output rpc_pkg::sres_t res
);

    localparam int NBITS = 96;

    logic             busy_reg;
    logic [6:0]       cnt_reg;
    logic [63:0]      r_reg, q_reg, md_reg;
    logic [NBITS-1:0] num_reg;
    logic             ovf_reg, neg_reg, zero_reg, nz_reg, nneg_reg;
    logic [64:0]      r2;
    logic             ge;

    assign r2 = {r_reg, num_reg[NBITS-1]};
    assign ge = (r2 >= {1'b0, md_reg});

    assign done = busy_reg && (zero_reg || cnt_reg == 7'(NBITS));

    always_comb
    begin
        if (zero_reg)
        begin
            res.err = 1'b1;
            res.v   = !nz_reg ? 64'd0 : (nneg_reg ? rpc_pkg::SAT_MIN : rpc_pkg::SAT_MAX);
        end
        else
        begin
            res = rpc_pkg::sat_mag(neg_reg, ovf_reg, q_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'd0;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            md_reg   <= d[63] ? (64'd0 - d) : d;
            num_reg  <= {(n[63] ? (64'd0 - n) : n), 32'd0};
            r_reg    <= 64'd0;
            q_reg    <= 64'd0;
            ovf_reg  <= 1'b0;
            neg_reg  <= n[63] ^ d[63];
            zero_reg <= (d == 64'd0);
            nz_reg   <= (n != 64'd0);
            nneg_reg <= n[63];
        end
        else if (busy_reg && !done)
        begin
            r_reg   <= ge ? 64'(r2 - {1'b0, md_reg}) : r2[63:0];
            q_reg   <= {q_reg[62:0], ge};
            ovf_reg <= ovf_reg | q_reg[63];
            num_reg <= {num_reg[NBITS-2:0], 1'b0};
        end
    end

endmodule

// ===== sv/rpc_back.sv =====
// Back end: model table, evaluation sequencer over shared multiplier and
// divider, and the result register. Depends on rpc_pkg, rpc_mul, rpc_div.
module rpc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  rpc_pkg::q_entry_t       q_head,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [63:0]      out_x,
    output logic signed [63:0]      out_y,
    output logic                    range_error,
    output logic                    last_out
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_N_OFF  = 17'h00002,
        S_N_SCL  = 17'h00004,
        S_N_DIV  = 17'h00008,
        S_N_WAIT = 17'h00010,
        S_P_MUL  = 17'h00020,
        S_P_WAIT = 17'h00040,
        S_A_RD   = 17'h00080,
        S_A_MUL  = 17'h00100,
        S_A_WAIT = 17'h00200,
        S_S_RD   = 17'h00400,
        S_S_MUL  = 17'h00800,
        S_S_WAIT = 17'h01000,
        S_D_DIV  = 17'h02000,
        S_D_WAIT = 17'h04000,
        S_O_RD   = 17'h08000,
        S_O_FIN  = 17'h10000
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  idx_reg, idx_next;
    logic        axis_reg, axis_next;
    logic        err_reg, err_next;

    logic [63:0] mem [rpc_pkg::TABLE_WORDS];
    logic [63:0] rdata_reg;
    logic [rpc_pkg::ADDR_W-1:0] raddr;
    logic        mem_we;

    logic [63:0] sx_reg, sy_reg, sz_reg, ox_reg, oy_reg;
    logic        resid_reg, last_reg;
    logic [63:0] tu_reg, tv_reg, tw_reg, tuv_reg, tuw_reg, tvw_reg, tuu_reg, tvv_reg, tww_reg;
    logic [63:0] acc_reg, num_reg, tmp_reg, rel_reg, imgx_reg;

    logic        out_valid_reg, out_last_reg, out_err_reg;
    logic [63:0] out_x_reg, out_y_reg;

    logic        mul_start, mul_done, div_start, div_done;
    logic [63:0] mul_a, mul_b, div_n, div_d;
    rpc_pkg::sres_t mul_res, div_res;

    rpc_pkg::sres_t diff_res, acc_res, fin_add, fin_s1, fin_s2;
    logic [63:0] src_sel, obs_sel, term, acc_base, fin_v;
    logic [3:0]  term_idx;
    logic        fin_err, out_load;

    rpc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    rpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .done  (div_done),
        .res   (div_res)
    );

    // Coefficients 0..9 pair with terms 0..9, coefficients 10..18 with terms 1..9.
    assign term_idx = (idx_reg < 5'd10) ? idx_reg[3:0] : 4'(idx_reg - 5'd9);

    always_comb
    begin
        case (term_idx)
            4'd0:    term = rpc_pkg::ONE_Q;
            4'd1:    term = tu_reg;
            4'd2:    term = tv_reg;
            4'd3:    term = tw_reg;
            4'd4:    term = tuv_reg;
            4'd5:    term = tuw_reg;
            4'd6:    term = tvw_reg;
            4'd7:    term = tuu_reg;
            4'd8:    term = tvv_reg;
            default: term = tww_reg;
        endcase
        case (idx_reg[1:0])
            2'd0:    src_sel = sx_reg;
            2'd1:    src_sel = sy_reg;
            default: src_sel = sz_reg;
        endcase
        if (idx_reg == 5'd0)
        begin
            acc_base = 64'd0;
        end
        else if (idx_reg == 5'd10)
        begin
            acc_base = rpc_pkg::ONE_Q;
        end
        else
        begin
            acc_base = acc_reg;
        end
    end

    assign obs_sel  = axis_reg ? oy_reg : ox_reg;
    assign diff_res = rpc_pkg::ssub(src_sel, rdata_reg);
    assign acc_res  = rpc_pkg::sadd(acc_base, mul_res.v);
    assign fin_add  = rpc_pkg::sadd(rdata_reg, rel_reg);
    assign fin_s1   = rpc_pkg::ssub(obs_sel, rdata_reg);
    assign fin_s2   = rpc_pkg::ssub(fin_s1.v, rel_reg);
    assign fin_v    = resid_reg ? fin_s2.v : fin_add.v;
    assign fin_err  = resid_reg ? (fin_s1.err | fin_s2.err) : fin_add.err;

    assign out_load = (state_reg == S_O_FIN) && axis_reg && (!out_valid_reg || out_ready);
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign mem_we   = q_pop && q_head.is_load;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        axis_next  = axis_reg;
        err_next   = err_reg;
        raddr      = '0;
        mul_start  = 1'b0;
        mul_a      = rdata_reg;
        mul_b      = term;
        div_start  = 1'b0;
        div_n      = tmp_reg;
        div_d      = rdata_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop && !q_head.is_load)
                begin
                    idx_next   = 5'd0;
                    err_next   = 1'b0;
                    state_next = S_N_OFF;
                end
            end
            S_N_OFF:
            begin
                raddr      = rpc_pkg::ADDR_W'(rpc_pkg::OFF_BASE + idx_reg);
                state_next = S_N_SCL;
            end
            S_N_SCL:
            begin
                raddr      = rpc_pkg::ADDR_W'(rpc_pkg::SCL_BASE + idx_reg);
                err_next   = err_reg | diff_res.err;
                state_next = S_N_DIV;
            end
            S_N_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_N_WAIT;
            end
            S_N_WAIT:
            begin
                if (div_done)
                begin
                    err_next = err_reg | div_res.err;
                    if (idx_reg == 5'd2)
                    begin
                        idx_next   = 5'd0;
                        state_next = S_P_MUL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 5'd1;
                        state_next = S_N_OFF;
                    end
                end
            end
            S_P_MUL:
            begin
                mul_start = 1'b1;
                case (idx_reg)
                    5'd0:    begin mul_a = tu_reg; mul_b = tv_reg; end
                    5'd1:    begin mul_a = tu_reg; mul_b = tw_reg; end
                    5'd2:    begin mul_a = tv_reg; mul_b = tw_reg; end
                    5'd3:    begin mul_a = tu_reg; mul_b = tu_reg; end
                    5'd4:    begin mul_a = tv_reg; mul_b = tv_reg; end
                    default: begin mul_a = tw_reg; mul_b = tw_reg; end
                endcase
                state_next = S_P_WAIT;
            end
            S_P_WAIT:
            begin
                if (mul_done)
                begin
                    err_next = err_reg | mul_res.err;
                    if (idx_reg == 5'd5)
                    begin
                        idx_next   = 5'd0;
                        axis_next  = 1'b0;
                        state_next = S_A_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 5'd1;
                        state_next = S_P_MUL;
                    end
                end
            end
            S_A_RD:
            begin
                raddr = axis_reg ? rpc_pkg::ADDR_W'(rpc_pkg::TERMS_PER_AXIS + int'(idx_reg))
                                 : rpc_pkg::ADDR_W'(idx_reg);
                state_next = S_A_MUL;
            end
            S_A_MUL:
            begin
                mul_start  = 1'b1;
                state_next = S_A_WAIT;
            end
            S_A_WAIT:
            begin
                if (mul_done)
                begin
                    err_next = err_reg | mul_res.err | acc_res.err;
                    if (idx_reg == 5'(rpc_pkg::TERMS_PER_AXIS - 1))
                    begin
                        idx_next   = 5'd0;
                        state_next = S_S_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 5'd1;
                        state_next = S_A_RD;
                    end
                end
            end
            S_S_RD:
            begin
                raddr      = rpc_pkg::ADDR_W'(rpc_pkg::DST_SCL_BASE + axis_reg);
                state_next = S_S_MUL;
            end
            S_S_MUL:
            begin
                mul_start  = 1'b1;
                mul_b      = num_reg;
                state_next = S_S_WAIT;
            end
            S_S_WAIT:
            begin
                if (mul_done)
                begin
                    err_next   = err_reg | mul_res.err;
                    state_next = S_D_DIV;
                end
            end
            S_D_DIV:
            begin
                div_start  = 1'b1;
                div_d      = acc_reg;
                state_next = S_D_WAIT;
            end
            S_D_WAIT:
            begin
                if (div_done)
                begin
                    err_next   = err_reg | div_res.err;
                    state_next = S_O_RD;
                end
            end
            S_O_RD:
            begin
                raddr      = rpc_pkg::ADDR_W'(rpc_pkg::DST_OFF_BASE + axis_reg);
                state_next = S_O_FIN;
            end
            S_O_FIN:
            begin
                if (!axis_reg)
                begin
                    err_next   = err_reg | fin_err;
                    axis_next  = 1'b1;
                    state_next = S_A_RD;
                end
                else if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 5'd0;
            axis_reg      <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            axis_reg  <= axis_next;
            err_reg   <= err_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_head.index] <= q_head.value;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && !q_head.is_load)
        begin
            sx_reg    <= q_head.sx;
            sy_reg    <= q_head.sy;
            sz_reg    <= q_head.sz;
            ox_reg    <= q_head.ox;
            oy_reg    <= q_head.oy;
            resid_reg <= q_head.resid;
            last_reg  <= q_head.last;
        end
        if (state_reg == S_N_SCL)
        begin
            tmp_reg <= diff_res.v;
        end
        if (state_reg == S_N_WAIT && div_done)
        begin
            case (idx_reg[1:0])
                2'd0:    tu_reg <= div_res.v;
                2'd1:    tv_reg <= div_res.v;
                default: tw_reg <= div_res.v;
            endcase
        end
        if (state_reg == S_P_WAIT && mul_done)
        begin
            case (idx_reg)
                5'd0:    tuv_reg <= mul_res.v;
                5'd1:    tuw_reg <= mul_res.v;
                5'd2:    tvw_reg <= mul_res.v;
                5'd3:    tuu_reg <= mul_res.v;
                5'd4:    tvv_reg <= mul_res.v;
                default: tww_reg <= mul_res.v;
            endcase
        end
        if (state_reg == S_A_WAIT && mul_done)
        begin
            acc_reg <= acc_res.v;
            if (idx_reg == 5'd9)
            begin
                num_reg <= acc_res.v;
            end
        end
        if (state_reg == S_S_WAIT && mul_done)
        begin
            tmp_reg <= mul_res.v;
        end
        if (state_reg == S_D_WAIT && div_done)
        begin
            rel_reg <= div_res.v;
        end
        if (state_reg == S_O_FIN && !axis_reg)
        begin
            imgx_reg <= fin_v;
        end
        if (out_load)
        begin
            out_x_reg    <= imgx_reg;
            out_y_reg    <= fin_v;
            out_err_reg  <= err_reg | fin_err;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign range_error = out_err_reg;
    assign last_out    = out_last_reg;

endmodule
